/* sv/cell_voltage_poll_parser_assert.svh */
// Assertion macros for the port checker of the cell voltage poll parser.
`ifndef CELL_VOLTAGE_POLL_PARSER_ASSERT_SVH
`define CELL_VOLTAGE_POLL_PARSER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define CVPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, active through reset.
`define CVPP_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cvpp_pkg.sv */
// Types, codes and constants of the cell voltage poll parser.
package cvpp_pkg;

    localparam int LINE_DEPTH_DEF = 16;

    localparam int ID_W      = 10;
    localparam int MV_W      = 14;
    localparam int WAIT_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 16;  // rx_byte(8), charge_done(1), zero fill
    localparam int IN_TUSER_W  = 2;   // action
    localparam int OUT_TDATA_W = 88;  // 82 bits of fields, zero fill
    localparam int OUT_TUSER_W = 3;   // event_res

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_V       = 8'h56;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] STATUS_MIN = 8'h80;

    localparam logic [MV_W-1:0]   MV_MAX       = 14'd9999;
    localparam logic [ID_W-1:0]   NUM_CELLS_RST = 10'd1;
    localparam logic [WAIT_W-1:0] TIMEOUT_RST  = 16'd100;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_START = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_READING  = 3'd1,
        EV_REPORT   = 3'd2,
        EV_CSUM_ERR = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_IGNORED  = 3'd5,
        EV_RESEND   = 3'd6,
        EV_REQUEST  = 3'd7
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CELLS    = 2'd0,
        CFG_CHECKSUM_ON  = 2'd1,
        CFG_RESP_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ID_W-1:0]   num_cells;
        logic              checksum_on;
        logic [WAIT_W-1:0] timeout;
    } t_cfg;

    // What the line collector reports for the current word.
    typedef struct packed {
        logic            line_end;   // CR closed a line
        logic            overflow;   // line store full, byte dropped
        logic            fmt_ok;     // length and layout good, all digits valid
        logic            xor_zero;   // XOR of bytes before CR is zero
        logic [ID_W-1:0] id;
        logic [MV_W-1:0] mv;
    } t_line_info;

    typedef struct packed {
        t_event          ev;
        logic [ID_W-1:0] request_cell;
        logic [ID_W-1:0] cell_id;
        logic [MV_W-1:0] cell_mv;
        logic [MV_W-1:0] min_mv;
        logic [ID_W-1:0] min_id;
        logic [MV_W-1:0] max_mv;
        logic [ID_W-1:0] max_id;
    } t_result;

endpackage

/* sv/cvpp_line.sv */
// Line collector: checks layout and gathers id and millivolts as bytes arrive.
module cvpp_line #(
    parameter int LINE_DEPTH = cvpp_pkg::LINE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_is_byte,
    input  logic [7:0]           i_byte,
    output cvpp_pkg::t_line_info o_info
);
    import cvpp_pkg::*;

    localparam int IDX_W = $clog2(LINE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(LINE_DEPTH);
    localparam logic [IDX_W-1:0] POS_SLASH = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_ID0   = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_ID2   = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_COLON = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_MV0   = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_MV3   = IDX_W'(8);
    localparam logic [IDX_W-1:0] POS_V     = IDX_W'(10);
    localparam logic [IDX_W-1:0] MIN_LEN   = IDX_W'(11);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_xor, n_xor;
    logic             r_ok, n_ok;
    logic [ID_W-1:0]  r_id, n_id;
    logic [MV_W-1:0]  r_mv, n_mv;

    logic       data_byte;
    logic       is_digit;
    logic [3:0] digit;
    logic       pos_good;
    logic       in_id, in_mv;

    always_comb begin
        data_byte = i_en && i_is_byte && (i_byte < STATUS_MIN);
        is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        digit     = 4'(i_byte - CH_ZERO);
        in_id     = (r_idx >= POS_ID0) && (r_idx <= POS_ID2);
        in_mv     = (r_idx >= POS_MV0) && (r_idx <= POS_MV3);

        if (r_idx == POS_SLASH) begin
            pos_good = (i_byte == CH_BSLASH);
        end else if (r_idx == POS_COLON) begin
            pos_good = (i_byte == CH_COLON);
        end else if (r_idx == POS_V) begin
            pos_good = (i_byte == CH_V);
        end else if (in_id || in_mv) begin
            pos_good = is_digit;
        end else begin
            pos_good = 1'b1;
        end

        o_info          = '0;
        o_info.id       = r_id;
        o_info.mv       = r_mv;
        o_info.xor_zero = (r_xor == 8'h00);
        o_info.fmt_ok   = r_ok && (r_idx >= MIN_LEN);

        n_idx = r_idx;
        n_xor = r_xor;
        n_ok  = r_ok;
        n_id  = r_id;
        n_mv  = r_mv;

        if (data_byte) begin
            if (r_idx == IDX_FULL) begin
                o_info.overflow = 1'b1;
                n_idx = '0;
                n_xor = '0;
                n_ok  = 1'b1;
                n_id  = '0;
                n_mv  = '0;
            end else if (i_byte == CH_CR) begin
                o_info.line_end = 1'b1;
                n_idx = '0;
                n_xor = '0;
                n_ok  = 1'b1;
                n_id  = '0;
                n_mv  = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
                n_xor = r_xor ^ i_byte;
                n_ok  = r_ok && pos_good;
                if (in_id) begin
                    n_id = (r_id << 3) + (r_id << 1) + ID_W'(digit);
                end
                if (in_mv) begin
                    n_mv = (r_mv << 3) + (r_mv << 1) + MV_W'(digit);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_xor <= '0;
            r_ok  <= 1'b1;
            r_id  <= '0;
            r_mv  <= '0;
        end else begin
            r_idx <= n_idx;
            r_xor <= n_xor;
            r_ok  <= n_ok;
            r_id  <= n_id;
            r_mv  <= n_mv;
        end
    end

endmodule

/* sv/cvpp_poll.sv */
// Poll control: reading acceptance, min/max tracking, request and timeout.
module cvpp_poll (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [1:0]           i_action,
    input  logic                 i_charge_done,
    input  cvpp_pkg::t_line_info i_info,
    input  cvpp_pkg::t_cfg       i_cfg,
    output cvpp_pkg::t_result    o_res
);
    import cvpp_pkg::*;

    logic [ID_W-1:0]   r_polled, n_polled;
    logic [MV_W-1:0]   r_low_mv, n_low_mv;
    logic [ID_W-1:0]   r_low_id, n_low_id;
    logic [MV_W-1:0]   r_high_mv, n_high_mv;
    logic [ID_W-1:0]   r_high_id, n_high_id;
    logic              r_awaiting, n_awaiting;
    logic [WAIT_W-1:0] r_wait, n_wait;

    logic [ID_W:0]     nxt_wide;
    logic [ID_W-1:0]   nxt;
    logic [WAIT_W-1:0] wait_dec;
    logic [MV_W-1:0]   upd_low_mv, upd_high_mv;
    logic [ID_W-1:0]   upd_low_id, upd_high_id;

    always_comb begin
        nxt_wide = {1'b0, r_polled} + (ID_W + 1)'(1);
        if (nxt_wide[ID_W] || (nxt_wide > {1'b0, i_cfg.num_cells})) begin
            nxt = ID_W'(1);
        end else begin
            nxt = nxt_wide[ID_W-1:0];
        end
        wait_dec = r_wait - WAIT_W'(1);

        upd_low_mv  = r_low_mv;
        upd_low_id  = r_low_id;
        upd_high_mv = r_high_mv;
        upd_high_id = r_high_id;
        if (i_info.mv < r_low_mv) begin
            upd_low_mv = i_info.mv;
            upd_low_id = i_info.id;
        end
        if (i_info.mv > r_high_mv) begin
            upd_high_mv = i_info.mv;
            upd_high_id = i_info.id;
        end

        o_res      = '0;
        o_res.ev   = EV_NONE;
        n_polled   = r_polled;
        n_low_mv   = r_low_mv;
        n_low_id   = r_low_id;
        n_high_mv  = r_high_mv;
        n_high_id  = r_high_id;
        n_awaiting = r_awaiting;
        n_wait     = r_wait;

        unique case (i_action)
            ACT_BYTE: begin
                if (i_info.overflow) begin
                    o_res.ev = EV_OVERFLOW;
                end else if (i_info.line_end) begin
                    priority if (i_charge_done) begin
                        o_res.ev = EV_IGNORED;
                    end else if (i_cfg.checksum_on && !i_info.xor_zero) begin
                        o_res.ev = EV_CSUM_ERR;
                    end else if (!i_info.fmt_ok || (i_info.id != r_polled)) begin
                        o_res.ev = EV_IGNORED;
                    end else begin
                        o_res.cell_id      = i_info.id;
                        o_res.cell_mv      = i_info.mv;
                        o_res.request_cell = nxt;
                        n_polled   = nxt;
                        n_awaiting = 1'b1;
                        n_wait     = i_cfg.timeout;
                        if (i_info.id >= i_cfg.num_cells) begin
                            // last cell of the round: report extremes, then clear
                            o_res.ev     = EV_REPORT;
                            o_res.min_mv = upd_low_mv;
                            o_res.min_id = upd_low_id;
                            o_res.max_mv = upd_high_mv;
                            o_res.max_id = upd_high_id;
                            n_low_mv  = MV_MAX;
                            n_low_id  = '0;
                            n_high_mv = '0;
                            n_high_id = '0;
                        end else begin
                            o_res.ev  = EV_READING;
                            n_low_mv  = upd_low_mv;
                            n_low_id  = upd_low_id;
                            n_high_mv = upd_high_mv;
                            n_high_id = upd_high_id;
                        end
                    end
                end
            end
            ACT_TICK: begin
                if (r_awaiting) begin
                    if (wait_dec == '0) begin
                        o_res.ev           = EV_RESEND;
                        o_res.request_cell = r_polled;
                        n_wait             = i_cfg.timeout;
                    end else begin
                        n_wait = wait_dec;
                    end
                end
            end
            ACT_START: begin
                o_res.ev           = EV_REQUEST;
                o_res.request_cell = r_polled;
                n_awaiting         = 1'b1;
                n_wait             = i_cfg.timeout;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polled   <= ID_W'(1);
            r_low_mv   <= MV_MAX;
            r_low_id   <= '0;
            r_high_mv  <= '0;
            r_high_id  <= '0;
            r_awaiting <= 1'b0;
            r_wait     <= '0;
        end else if (i_en) begin
            r_polled   <= n_polled;
            r_low_mv   <= n_low_mv;
            r_low_id   <= n_low_id;
            r_high_mv  <= n_high_mv;
            r_high_id  <= n_high_id;
            r_awaiting <= n_awaiting;
            r_wait     <= n_wait;
        end
    end

endmodule

/* sv/cell_voltage_poll_parser.sv */
// Top level of the cell voltage poll parser: word registers, config, parser core.
//
//  channel  dir  tdata (low bit up)                           tuser
//  s        in   rx_byte[7:0], charge_done[8], zero[15:9]     action[1:0]
//  m        out  request_cell, cell_id, cell_mv, min_mv,      event_res[2:0]
//                min_id, max_mv, max_id, zero[87:82]
//  cfg      in   i_cfg_we / i_cfg_idx / i_cfg_data: num_cells, checksum_on,
//                response_timeout
//
// One word in and one word out per cycle, sustained while i_m_tready is high.
// The path holds two registers, the input word register and then the result
// register; the parse state updates as the word leaves the input register.
// o_s_tready is high while the input register is empty or can drain, so it
// follows i_m_tready combinationally; a stalled result holds its data.
// Reset (i_rst_n low, synchronous) empties both registers and loads the
// config and parse state with their start values; no clearing pass.
module cell_voltage_poll_parser #(
    parameter int LINE_DEPTH = cvpp_pkg::LINE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [cvpp_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // rx_byte, charge_done
    input  logic [cvpp_pkg::IN_TUSER_W-1:0]  i_s_tuser,   // action
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // request_cell, cell_id, cell_mv, min_mv, min_id, max_mv, max_id
    output logic [cvpp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [cvpp_pkg::OUT_TUSER_W-1:0] o_m_tuser,   // event_res
    // config writes
    input  logic                             i_cfg_we,
    input  logic [cvpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cvpp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cvpp_pkg::*;

    t_cfg r_cfg;

    // input word register
    logic       r_in_valid;
    logic [1:0] r_in_action;
    logic [7:0] r_in_byte;
    logic       r_in_done;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic       out_adv;
    logic       work_en;
    t_line_info line_info;
    t_result    res;

    assign out_adv    = !r_out_valid || i_m_tready;
    assign work_en    = r_in_valid && out_adv;
    assign o_s_tready = !r_in_valid || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_cells   <= NUM_CELLS_RST;
            r_cfg.checksum_on <= 1'b0;
            r_cfg.timeout     <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_CELLS:    r_cfg.num_cells   <= i_cfg_data[ID_W-1:0];
                CFG_CHECKSUM_ON:  r_cfg.checksum_on <= i_cfg_data[0];
                CFG_RESP_TIMEOUT: r_cfg.timeout     <= i_cfg_data[WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_action <= i_s_tuser;
            r_in_byte   <= i_s_tdata[7:0];
            r_in_done   <= i_s_tdata[8];
        end
    end

    cvpp_line #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (work_en),
        .i_is_byte (r_in_action == ACT_BYTE),
        .i_byte    (r_in_byte),
        .o_info    (line_info)
    );

    cvpp_poll u_poll (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (work_en),
        .i_action      (r_in_action),
        .i_charge_done (r_in_done),
        .i_info        (line_info),
        .i_cfg         (r_cfg),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_en) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.ev;
    assign o_m_tdata  = {6'b0,
                         r_out.max_id, r_out.max_mv, r_out.min_id, r_out.min_mv,
                         r_out.cell_mv, r_out.cell_id, r_out.request_cell};

endmodule

/* sv/cvpp_checker.sv */
// Port-level checker for the cell voltage poll parser, bound to the top level.
`include "cell_voltage_poll_parser_assert.svh"

module cvpp_port_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [cvpp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [cvpp_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import cvpp_pkg::*;

    // reset empties the result register
    `CVPP_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid, "result valid after reset")

    // a stalled result word holds
    `CVPP_ASSERT_IMP(a_hold, i_clk, i_rst_n,
        $past(i_rst_n) && $past(o_m_tvalid && !i_m_tready),
        $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    // events without a reading or request carry all-zero data
    `CVPP_ASSERT_IMP(a_quiet_zero, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser == EV_NONE || o_m_tuser == EV_CSUM_ERR ||
                       o_m_tuser == EV_OVERFLOW || o_m_tuser == EV_IGNORED),
        o_m_tdata == '0, "data on a quiet event")

    // requests always name a real cell
    `CVPP_ASSERT_IMP(a_req_cell, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser == EV_READING || o_m_tuser == EV_REPORT ||
                       o_m_tuser == EV_RESEND || o_m_tuser == EV_REQUEST),
        o_m_tdata[9:0] != '0, "request for cell zero")

    // extremes only travel with a report
    `CVPP_ASSERT_IMP(a_no_extremes, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser == EV_READING,
        o_m_tdata[81:34] == '0, "extremes on a plain reading")

endmodule

bind cell_voltage_poll_parser cvpp_port_checker u_port_checker (.*);

/* verif/cvpp_checker.sv */
// Result checker for the cell voltage poll parser: predicts each output word and compares.
`timescale 1ns / 1ps

module cvpp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [cvpp_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // rx_byte, charge_done
    input  logic [cvpp_pkg::IN_TUSER_W-1:0]  i_s_tuser,   // action
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // request_cell, cell_id, cell_mv, min_mv, min_id, max_mv, max_id
    input  logic [cvpp_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [cvpp_pkg::OUT_TUSER_W-1:0] i_m_tuser,   // event_res
    input  logic                             i_cfg_we,
    input  logic [cvpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cvpp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output logic [cvpp_pkg::ID_W-1:0]        o_next_poll
);
    import cvpp_pkg::*;

    // register copies
    logic [ID_W-1:0]   cells_per_round;
    logic              csum_enable;
    logic [WAIT_W-1:0] reply_timeout;

    // parser state
    logic [7:0]        line_buf [0:LINE_DEPTH_DEF-1];
    int                line_fill;
    logic [7:0]        line_parity;
    logic [ID_W-1:0]   poll_cell;
    logic [MV_W-1:0]   round_low_mv;
    logic [ID_W-1:0]   round_low_id;
    logic [MV_W-1:0]   round_high_mv;
    logic [ID_W-1:0]   round_high_id;
    logic              reply_due;
    logic [WAIT_W-1:0] ticks_left;

    t_result           result_fifo [$];
    int                mismatch_count;

    string field_name [0:7] = '{"event_res", "request_cell", "cell_id", "cell_mv",
                                "min_mv", "min_id", "max_mv", "max_id"};

    // Advances the parser by one input word and returns the result word it causes.
    function automatic t_result parse_word(logic [1:0] act, logic [7:0] rx, logic done);
        t_result    r;
        int         len;
        logic [7:0] parity;
        int         digit [0:6];
        int         pos;
        int         id;
        int         mv;
        int         nxt;
        bit         ok;
        r = '0;
        r.ev = EV_NONE;
        case (act)
            ACT_BYTE: begin
                if (rx < STATUS_MIN) begin
                    if (line_fill >= LINE_DEPTH_DEF) begin
                        line_fill = 0;
                        line_parity = '0;
                        r.ev = EV_OVERFLOW;
                    end else begin
                        line_buf[line_fill] = rx;
                        line_fill++;
                        if (rx == CH_CR) begin
                            len = line_fill - 1;
                            parity = line_parity;
                            line_fill = 0;
                            line_parity = '0;
                            if (done) begin
                                r.ev = EV_IGNORED;
                            end else if (csum_enable && parity != 8'd0) begin
                                r.ev = EV_CSUM_ERR;
                            end else begin
                                ok = (len >= 11) && line_buf[0] == CH_BSLASH &&
                                     line_buf[4] == CH_COLON && line_buf[10] == CH_V;
                                // digits sit at 1..3 (id) and 5..8 (millivolts)
                                for (int k = 0; k < 7; k++) begin
                                    pos = (k < 3) ? k + 1 : k + 2;
                                    if (line_buf[pos] < CH_ZERO || line_buf[pos] > CH_NINE)
                                        ok = 0;
                                    else
                                        digit[k] = int'(line_buf[pos] - CH_ZERO);
                                end
                                if (ok) begin
                                    id = digit[0] * 100 + digit[1] * 10 + digit[2];
                                    mv = digit[3] * 1000 + digit[4] * 100 + digit[5] * 10
                                         + digit[6];
                                    if (id != int'(poll_cell))
                                        ok = 0;
                                end
                                if (!ok) begin
                                    r.ev = EV_IGNORED;
                                end else begin
                                    if (mv < int'(round_low_mv)) begin
                                        round_low_mv = MV_W'(mv);
                                        round_low_id = ID_W'(id);
                                    end
                                    if (mv > int'(round_high_mv)) begin
                                        round_high_mv = MV_W'(mv);
                                        round_high_id = ID_W'(id);
                                    end
                                    r.ev = EV_READING;
                                    r.cell_id = ID_W'(id);
                                    r.cell_mv = MV_W'(mv);
                                    if (id >= int'(cells_per_round)) begin
                                        r.ev = EV_REPORT;
                                        r.min_mv = round_low_mv;
                                        r.min_id = round_low_id;
                                        r.max_mv = round_high_mv;
                                        r.max_id = round_high_id;
                                        round_low_mv = MV_MAX;
                                        round_low_id = '0;
                                        round_high_mv = '0;
                                        round_high_id = '0;
                                    end
                                    nxt = int'(poll_cell) + 1;
                                    if (nxt > int'(cells_per_round) || nxt > 1023)
                                        nxt = 1;
                                    poll_cell = ID_W'(nxt);
                                    reply_due = 1'b1;
                                    ticks_left = reply_timeout;
                                    r.request_cell = poll_cell;
                                end
                            end
                        end else begin
                            line_parity ^= rx;
                        end
                    end
                end
            end
            ACT_TICK: begin
                if (reply_due) begin
                    ticks_left = ticks_left - WAIT_W'(1);
                    if (ticks_left == '0) begin
                        ticks_left = reply_timeout;
                        r.request_cell = poll_cell;
                        r.ev = EV_RESEND;
                    end
                end
            end
            ACT_START: begin
                reply_due = 1'b1;
                ticks_left = reply_timeout;
                r.request_cell = poll_cell;
                r.ev = EV_REQUEST;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result     want;
        logic [15:0] want_f [0:7];
        logic [15:0] got_f [0:7];
        if (!i_rst_n) begin
            cells_per_round = NUM_CELLS_RST;
            csum_enable = 1'b0;
            reply_timeout = TIMEOUT_RST;
            for (int k = 0; k < LINE_DEPTH_DEF; k++)
                line_buf[k] = '0;
            line_fill = 0;
            line_parity = '0;
            poll_cell = ID_W'(1);
            round_low_mv = MV_MAX;
            round_low_id = '0;
            round_high_mv = '0;
            round_high_id = '0;
            reply_due = 1'b0;
            ticks_left = '0;
            result_fifo.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_CELLS:    cells_per_round = i_cfg_data[ID_W-1:0];
                    CFG_CHECKSUM_ON:  csum_enable = i_cfg_data[0];
                    CFG_RESP_TIMEOUT: reply_timeout = i_cfg_data[WAIT_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting: an output word never belongs to the
            // input word taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (result_fifo.size() == 0) begin
                    $error("unexpected result word, event_res %0d", i_m_tuser);
                    mismatch_count++;
                end else begin
                    want = result_fifo.pop_front();
                    want_f[0] = 16'(want.ev);
                    want_f[1] = 16'(want.request_cell);
                    want_f[2] = 16'(want.cell_id);
                    want_f[3] = 16'(want.cell_mv);
                    want_f[4] = 16'(want.min_mv);
                    want_f[5] = 16'(want.min_id);
                    want_f[6] = 16'(want.max_mv);
                    want_f[7] = 16'(want.max_id);
                    got_f[0] = 16'(i_m_tuser);
                    got_f[1] = 16'(i_m_tdata[9:0]);
                    got_f[2] = 16'(i_m_tdata[19:10]);
                    got_f[3] = 16'(i_m_tdata[33:20]);
                    got_f[4] = 16'(i_m_tdata[47:34]);
                    got_f[5] = 16'(i_m_tdata[57:48]);
                    got_f[6] = 16'(i_m_tdata[71:58]);
                    got_f[7] = 16'(i_m_tdata[81:72]);
                    for (int k = 0; k < 8; k++) begin
                        if (got_f[k] !== want_f[k]) begin
                            $error("%s: expected %0d, got %0d", field_name[k], want_f[k],
                                   got_f[k]);
                            mismatch_count++;
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                result_fifo.push_back(parse_word(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8]));
        end
        o_fail_count <= mismatch_count;
        o_pending <= result_fifo.size();
        o_next_poll <= poll_cell;
    end

endmodule

/* verif/testbench.sv */
// Testbench top for the cell voltage poll parser: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module testbench;
    import cvpp_pkg::*;

    // action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // cycles with no word moving on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS = 200;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // rx_byte[7:0], charge_done[8], zero fill
    logic [IN_TUSER_W-1:0]  i_s_tuser;   // action
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // request_cell, cell_id, cell_mv, min_mv, min_id, max_mv, max_id, zero fill
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;   // event_res
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int                     fail_count;
    int                     results_pending;
    logic [ID_W-1:0]        next_poll;     // cell the parser will accept next

    int                     sender_idle_pct;
    int                     recv_stall_pct;
    int                     words_sent;
    int                     quiet_cycles;
    bit                     csum_sel;      // checksum mode currently programmed

    cell_voltage_poll_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cvpp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_pending),
        .o_next_poll  (next_poll)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: per-cycle random stall at the phase's rate.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Printable text, never CR and never a status byte.
    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(8'h7E, 8'h20));
    endfunction

    function automatic logic [7:0] status_byte();
        return STATUS_MIN | 8'($urandom_range(127));
    endfunction

    // Presents one word and returns at the edge that takes it. tvalid stays
    // high into the next word unless a sender gap is drawn here; each gap
    // cycle repeats at the phase's idle rate.
    task automatic send_word(input logic [1:0] act, input logic [7:0] rx, input logic done);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, done, rx};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Drops tvalid and holds off until every predicted result has come out.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    // Writes all three registers back to back; only called with the block idle.
    task automatic write_regs(input int cells, input bit csum, input int tmo);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NUM_CELLS;
        i_cfg_data <= CFG_DATA_W'(cells);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CHECKSUM_ON;
        i_cfg_data <= CFG_DATA_W'(csum);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RESP_TIMEOUT;
        i_cfg_data <= CFG_DATA_W'(tmo);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        csum_sel = csum;
    endtask

    // Fixed text followed by CR; charge_done goes with the CR.
    task automatic send_text(input string s, input logic done);
        for (int i = 0; i < s.len(); i++)
            send_word(ACT_BYTE, s[i], 1'b0);
        send_word(ACT_BYTE, CH_CR, done);
    endtask

    // One "\ddd:dddd V" line, mostly well formed and addressed to the polled
    // cell. About a quarter is broken: bad digit, bad separator, truncated,
    // charging ended, or a wrong checksum byte.
    task automatic send_reading_line();
        logic [7:0] ln [0:15];
        logic [7:0] chk;
        int         len;
        int         kind;
        int         id;
        int         mv;
        int         pos;
        kind = $urandom_range(99);
        ln[0] = CH_BSLASH;
        if (kind >= 80 && kind < 85 && $urandom_range(2) == 0)
            ln[0] = text_byte();
        send_word(ACT_BYTE, ln[0], 1'($urandom_range(1)));
        // the poll hint is read only now, after the previous CR has been predicted
        id = ($urandom_range(99) < 85) ? int'(next_poll) : $urandom_range(999);
        case ($urandom_range(9))
            0:       mv = 0;
            1:       mv = 9999;
            default: mv = $urandom_range(9999);
        endcase
        ln[1]  = CH_ZERO + 8'(id / 100);
        ln[2]  = CH_ZERO + 8'((id / 10) % 10);
        ln[3]  = CH_ZERO + 8'(id % 10);
        ln[4]  = CH_COLON;
        ln[5]  = CH_ZERO + 8'(mv / 1000);
        ln[6]  = CH_ZERO + 8'((mv / 100) % 10);
        ln[7]  = CH_ZERO + 8'((mv / 10) % 10);
        ln[8]  = CH_ZERO + 8'(mv % 10);
        ln[9]  = text_byte();
        ln[10] = CH_V;
        len = 11;
        // trailing text after the V is allowed
        repeat ($urandom_range(3)) begin
            ln[len] = text_byte();
            len++;
        end
        if (kind >= 75 && kind < 80) begin
            pos = $urandom_range(6);
            pos = (pos < 3) ? pos + 1 : pos + 2;
            do ln[pos] = text_byte(); while (ln[pos] >= CH_ZERO && ln[pos] <= CH_NINE);
        end else if (kind >= 80 && kind < 85 && ln[0] == CH_BSLASH) begin
            ln[$urandom_range(1) ? 4 : 10] = text_byte();
        end else if (kind >= 85 && kind < 90) begin
            len = $urandom_range(1, 10);
        end
        // checksum byte makes the XOR of the line zero; it must not read as CR
        if (csum_sel && !(kind >= 85 && kind < 90)) begin
            do begin
                chk = '0;
                for (int i = 0; i < len; i++)
                    chk ^= ln[i];
                if (chk == CH_CR)
                    ln[9] = text_byte();
            end while (chk == CH_CR);
            if (kind >= 95)
                do ln[len] = text_byte(); while (ln[len] == chk);
            else
                ln[len] = chk;
            len++;
        end
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(24) == 0)
                send_word(ACT_BYTE, status_byte(), 1'($urandom_range(1)));
            send_word(ACT_BYTE, ln[i], 1'($urandom_range(1)));
        end
        send_word(ACT_BYTE, CH_CR, kind >= 90 && kind < 95);
    endtask

    // Random traffic until n more words have gone in.
    task automatic run_traffic(input int n);
        int target;
        int pick;
        target = words_sent + n;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_reading_line();
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 5))
                    send_word(ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (pick < 80) begin
                send_word(ACT_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (pick < 90) begin
                // noise, usually closed by a CR so the next line starts clean
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                if ($urandom_range(9) < 7)
                    send_word(ACT_BYTE, CH_CR, 1'b0);
            end else if (pick < 95) begin
                // fill the line store, then one more byte (CR or text) overflows it
                repeat (LINE_DEPTH_DEF)
                    send_word(ACT_BYTE, text_byte(), 1'b0);
                send_word(ACT_BYTE, $urandom_range(1) ? CH_CR : text_byte(), 1'b0);
            end else begin
                send_word(ACT_BYTE, status_byte(), 1'($urandom_range(1)));
            end
        end
    endtask

    // One setting of the registers and pacing; pauses midway until the
    // block has caught up.
    task automatic run_phase(input int cells, input bit csum, input int tmo,
                             input int idle_pct, input int stall_pct);
        drain();
        write_regs(cells, csum, tmo);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        run_traffic(PHASE_WORDS / 2);
        drain();
        run_traffic(PHASE_WORDS - PHASE_WORDS / 2);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_s_tuser       = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        words_sent      = 0;
        csum_sel        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one cell per round, short timeout
        write_regs(1, 1'b0, 2);
        send_word(ACT_TICK, 8'h00, 1'b0);       // tick with no request out: nothing
        send_word(ACT_START, 8'hFF, 1'b1);      // request for cell 1
        send_word(ACT_TICK, 8'h00, 1'b0);
        send_word(ACT_TICK, 8'h00, 1'b0);       // timeout: request resent
        send_word(ACT_BYTE, STATUS_MIN, 1'b0);  // status bytes are dropped
        send_word(ACT_BYTE, 8'hFF, 1'b1);
        send_word(ACT_UNUSED, 8'h55, 1'b1);     // unknown action: nothing
        send_text("\\001:0000 V", 1'b0);        // last cell of the round: report
        send_text("", 1'b0);                    // empty line is too short
        send_word(ACT_BYTE, 8'h00, 1'b0);
        send_text("", 1'b1);                    // line closed after charging ended

        // pacing phases: none, sender gaps, receiver stalls, both, none
        run_phase(3,   1'b0, 3,     0,  0);
        run_phase(1,   1'b1, 1,     59, 0);
        run_phase(999, 1'b0, 65535, 0,  59);
        run_phase(5,   1'b1, 7,     38, 38);
        run_phase(2,   1'b0, 2,     0,  0);

        drain();
        // a few quiet cycles so a stray extra result word would still be seen
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
